// ===== rtl/core/three_queue_transfer_manager_defines.svh =====
// Assertion macros used by the transfer manager back end RTL.
`ifndef THREE_QUEUE_TRANSFER_MANAGER_DEFINES_SVH
`define THREE_QUEUE_TRANSFER_MANAGER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TQTM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TQTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tqtm_pkg.sv =====
// Shared types, constants and address helpers for the transfer manager.
package tqtm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QUEUE_COUNT = 3;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int QIDX_W      = 2;
  localparam int ITEM_W      = 8;
  localparam int STORE_DEPTH = QUEUE_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // command queue between front and back (power of two)
  localparam int CMD_DEPTH  = 2;
  localparam int CPTR_W     = $clog2(CMD_DEPTH);
  localparam int CFILL_W    = $clog2(CMD_DEPTH + 1);

  localparam logic [QIDX_W-1:0] QUEUE_LAST = QIDX_W'(QUEUE_COUNT - 1);
  localparam logic [QIDX_W-1:0] QUEUE_LIM  = QIDX_W'(QUEUE_COUNT);

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_SERVE = 2'd2,
    KIND_DUMP  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_XFER = 2'd1,
    OP_POP  = 2'd2,
    OP_DUMP = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [QIDX_W-1:0] src;
    logic [QIDX_W-1:0] dst;
    logic [ITEM_W-1:0] value;
  } cmd_t;

  // ring slot at base + offset, offset never above the depth
  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return SLOT_W'(sum);
  endfunction

  // store address of a slot within a queue's region
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [QIDX_W-1:0] q,
                                                  input logic [SLOT_W-1:0] slot);
    return ADDR_W'(ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot));
  endfunction

endpackage

// ===== rtl/core/tqtm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tqtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tqtm_front.sv =====
// Front end: takes items, classifies them into commands, queues them for the back end.
module tqtm_front import tqtm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind_i,
  input  logic [QIDX_W-1:0] source_queue_i,
  input  logic [QIDX_W-1:0] target_queue_i,
  input  logic [ITEM_W-1:0] item_value_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  cmd_t               fifo_q [CMD_DEPTH];
  logic [CPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CFILL_W-1:0] fill_q;
  cmd_t               cls_cmd;
  logic               cls_valid;
  logic               accept, push, pop;
  logic               src_ok, dst_ok;

  // classify: drop items that can do nothing, fold special cases
  assign src_ok = source_queue_i < QUEUE_LIM;
  assign dst_ok = target_queue_i < QUEUE_LIM;

  always_comb begin
    cls_cmd.src   = source_queue_i;
    cls_cmd.dst   = target_queue_i;
    cls_cmd.value = item_value_i;
    cls_cmd.op    = OP_DUMP;
    cls_valid     = 1'b0;
    case (kind_e'(kind_i))
      KIND_ADD: begin
        cls_cmd.op  = OP_PUSH;
        cls_cmd.dst = dst_ok ? target_queue_i : QUEUE_LAST;
        cls_valid   = 1'b1;
      end
      KIND_MOVE: begin
        // move onto itself only discards the head
        cls_cmd.op = (source_queue_i == target_queue_i) ? OP_POP : OP_XFER;
        cls_valid  = src_ok && dst_ok;
      end
      KIND_SERVE: begin
        cls_cmd.op = OP_POP;
        cls_valid  = src_ok;
      end
      KIND_DUMP: begin
        cls_cmd.op = OP_DUMP;
        cls_valid  = 1'b1;
      end
      default: begin
        cls_valid = 1'b0;
      end
    endcase
  end

  assign busy        = (fill_q == CFILL_W'(CMD_DEPTH));
  assign accept      = start && !busy;
  assign push        = accept && cls_valid;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  // command queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls_cmd;
    end
  end

  // command queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + CPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + CPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill_q <= fill_q + CFILL_W'(1);
        2'b01:   fill_q <= fill_q - CFILL_W'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/tqtm_back.sv =====
// Back end: runs queued commands against the item store and drains queues on dump.
`include "three_queue_transfer_manager_defines.svh"

module tqtm_back import tqtm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output logic              result_valid_o,
  output logic [QIDX_W-1:0] queue_index_o,
  output logic [ITEM_W-1:0] item_out_o,
  output logic              empty_marker_o,
  output logic              last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE_WR,
    ST_DUMP_RD,
    ST_DUMP_DATA
  } state_e;

  state_e            state_q;
  logic [SLOT_W-1:0] head_q  [QUEUE_COUNT];
  logic [CNT_W-1:0]  count_q [QUEUE_COUNT];
  logic [QIDX_W-1:0] dump_q, mv_dst_q;
  logic              out_valid_q, out_marker_q, out_last_q;
  logic [QIDX_W-1:0] out_qidx_q;
  logic [ITEM_W-1:0] out_item_q;

  logic [QIDX_W-1:0] sel_qidx;
  logic [SLOT_W-1:0] head_sel, head_next;
  logic [CNT_W-1:0]  count_sel;
  logic              sel_full, sel_empty;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ITEM_W-1:0] ram_wdata, ram_rdata;
  logic              idle_cmd;

  assign idle_cmd  = (state_q == ST_IDLE) && cmd_valid_i;
  assign cmd_pop_o = idle_cmd;

  // one queue is touched per cycle: pick it
  always_comb begin
    case (state_q)
      ST_IDLE:    sel_qidx = (cmd_i.op == OP_PUSH) ? cmd_i.dst : cmd_i.src;
      ST_MOVE_WR: sel_qidx = mv_dst_q;
      default:    sel_qidx = dump_q;
    endcase
  end

  assign head_sel  = head_q[sel_qidx];
  assign count_sel = count_q[sel_qidx];
  assign sel_full  = (count_sel == CNT_W'(QUEUE_DEPTH));
  assign sel_empty = (count_sel == '0);
  assign head_next = wrap_slot(head_sel, CNT_W'(1));

  // store ports: tail write, head read
  assign ram_we    = (idle_cmd && cmd_i.op == OP_PUSH && !sel_full) ||
                     (state_q == ST_MOVE_WR && !sel_full);
  assign ram_waddr = slot_addr(sel_qidx, wrap_slot(head_sel, count_sel));
  assign ram_wdata = (state_q == ST_MOVE_WR) ? ram_rdata : cmd_i.value;
  assign ram_re    = (idle_cmd && cmd_i.op == OP_XFER && !sel_empty) ||
                     (state_q == ST_DUMP_RD && !sel_empty);
  assign ram_raddr = slot_addr(sel_qidx, head_sel);

  tqtm_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer, queue pointers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      dump_q       <= '0;
      mv_dst_q     <= '0;
      out_valid_q  <= 1'b0;
      out_marker_q <= 1'b0;
      out_last_q   <= 1'b0;
      out_qidx_q   <= '0;
      out_item_q   <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              OP_PUSH: begin
                if (!sel_full) begin
                  count_q[sel_qidx] <= count_sel + CNT_W'(1);
                end
              end
              OP_POP: begin
                if (!sel_empty) begin
                  head_q[sel_qidx]  <= head_next;
                  count_q[sel_qidx] <= count_sel - CNT_W'(1);
                end
              end
              OP_XFER: begin
                if (!sel_empty) begin
                  head_q[sel_qidx]  <= head_next;
                  count_q[sel_qidx] <= count_sel - CNT_W'(1);
                  mv_dst_q          <= cmd_i.dst;
                  state_q           <= ST_MOVE_WR;
                end
              end
              OP_DUMP: begin
                dump_q  <= '0;
                state_q <= ST_DUMP_RD;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_MOVE_WR: begin
          // popped item lands in the store this cycle unless the target queue is full
          if (!sel_full) begin
            count_q[sel_qidx] <= count_sel + CNT_W'(1);
          end
          state_q <= ST_IDLE;
        end
        ST_DUMP_RD: begin
          if (sel_empty) begin
            // empty queue: one marker result
            out_valid_q      <= 1'b1;
            out_qidx_q       <= dump_q;
            out_item_q       <= '0;
            out_marker_q     <= 1'b1;
            out_last_q       <= (dump_q == QUEUE_LAST);
            head_q[sel_qidx] <= '0;
            if (dump_q == QUEUE_LAST) begin
              state_q <= ST_IDLE;
            end else begin
              dump_q <= dump_q + QIDX_W'(1);
            end
          end else begin
            head_q[sel_qidx]  <= head_next;
            count_q[sel_qidx] <= count_sel - CNT_W'(1);
            state_q           <= ST_DUMP_DATA;
          end
        end
        ST_DUMP_DATA: begin
          out_valid_q  <= 1'b1;
          out_qidx_q   <= dump_q;
          out_item_q   <= ram_rdata;
          out_marker_q <= 1'b0;
          out_last_q   <= (dump_q == QUEUE_LAST) && sel_empty;
          if (sel_empty) begin
            head_q[sel_qidx] <= '0;
            if (dump_q == QUEUE_LAST) begin
              state_q <= ST_IDLE;
            end else begin
              dump_q  <= dump_q + QIDX_W'(1);
              state_q <= ST_DUMP_RD;
            end
          end else begin
            state_q <= ST_DUMP_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = out_valid_q;
  assign queue_index_o  = out_qidx_q;
  assign item_out_o     = out_item_q;
  assign empty_marker_o = out_marker_q;
  assign last_o         = out_last_q;

  // checks
  `TQTM_ASSERT_NOW(a_count_bound, 1'b1,
    count_q[0] <= CNT_W'(QUEUE_DEPTH) && count_q[1] <= CNT_W'(QUEUE_DEPTH) &&
    count_q[2] <= CNT_W'(QUEUE_DEPTH), "queue fill count above depth")
  `TQTM_ASSERT_NOW(a_port_excl, ram_we, !ram_re, "store read and write in one cycle")
  `TQTM_ASSERT_NOW(a_data_after_read, state_q == ST_DUMP_DATA, $past(ram_re),
    "dump data cycle without a store read")
  `TQTM_ASSERT_NOW(a_dump_clears, out_valid_q && out_last_q,
    state_q == ST_IDLE && count_q[0] == '0 && count_q[1] == '0 && count_q[2] == '0,
    "queues not empty after final dump result")
  `TQTM_ASSERT_NEXT(a_marker_zero, result_valid_o && empty_marker_o,
    !result_valid_o || !empty_marker_o || queue_index_o != $past(queue_index_o),
    "two markers for one queue")

endmodule

// ===== rtl/core/three_queue_transfer_manager.sv =====
// Top level of the three-queue transfer manager: front end, command queue and back end.
//
//  channel   handshake                        payload
//  --------  -------------------------------  ---------------------------------------------
//  command   start & !busy accepts the item   kind_i, source_queue_i, target_queue_i,
//                                             item_value_i
//  result    result_valid_o, one cycle each   queue_index_o, item_out_o, empty_marker_o,
//                                             last_o
//
// Add and serve finish in the idle state; move reads the store there, then writes
// in ST_MOVE_WR. Dump leaves idle, then per stored item reads the head (ST_DUMP_RD)
// and registers the result (ST_DUMP_DATA), with one marker per empty queue.
// busy is high while the two-entry command queue is full; the back end pops it
// only between commands. Reset clears queue pointers and fill counts; the item
// store is not cleared. Results cannot be stalled.
module three_queue_transfer_manager import tqtm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind_i,
  input  logic [QIDX_W-1:0] source_queue_i,
  input  logic [QIDX_W-1:0] target_queue_i,
  input  logic [ITEM_W-1:0] item_value_i,
  output logic              result_valid_o,
  output logic [QIDX_W-1:0] queue_index_o,
  output logic [ITEM_W-1:0] item_out_o,
  output logic              empty_marker_o,
  output logic              last_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  tqtm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .source_queue_i (source_queue_i),
    .target_queue_i (target_queue_i),
    .item_value_i   (item_value_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  tqtm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .result_valid_o (result_valid_o),
    .queue_index_o  (queue_index_o),
    .item_out_o     (item_out_o),
    .empty_marker_o (empty_marker_o),
    .last_o         (last_o)
  );

endmodule

// ===== tb/three_queue_transfer_manager_tb.sv =====
// Self-checking testbench for the three-queue transfer manager, with a shadow queue predictor.
`timescale 1ns / 1ps

module three_queue_transfer_manager_tb;
  import tqtm_pkg::*;

  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 10;
  localparam int MAX_GAP       = 40;

  // one drained item or empty marker as the block should emit it
  typedef struct packed {
    logic [QIDX_W-1:0] qidx;
    logic [ITEM_W-1:0] data;
    logic              empty;
    logic              last;
  } drain_rec_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        kind_i;
  logic [QIDX_W-1:0] source_queue_i;
  logic [QIDX_W-1:0] target_queue_i;
  logic [ITEM_W-1:0] item_value_i;
  logic              result_valid_o;
  logic [QIDX_W-1:0] queue_index_o;
  logic [ITEM_W-1:0] item_out_o;
  logic              empty_marker_o;
  logic              last_o;

  // shadow copy of the three rings
  logic [ITEM_W-1:0] shadow_store [QUEUE_COUNT][QUEUE_DEPTH];
  logic [SLOT_W-1:0] shadow_head  [QUEUE_COUNT];
  logic [CNT_W-1:0]  shadow_fill  [QUEUE_COUNT];

  drain_rec_t pending_drain [$];

  int sender_idle_pct = 0;
  int items_sent      = 0;
  int results_seen    = 0;
  int mismatch_count  = 0;
  int kind_count [4];

  three_queue_transfer_manager i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .source_queue_i (source_queue_i),
    .target_queue_i (target_queue_i),
    .item_value_i   (item_value_i),
    .result_valid_o (result_valid_o),
    .queue_index_o  (queue_index_o),
    .item_out_o     (item_out_o),
    .empty_marker_o (empty_marker_o),
    .last_o         (last_o)
  );

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endfunction

  // append to a shadow ring; a full ring drops the item
  function automatic void push_shadow(input logic [QIDX_W-1:0] q, input logic [ITEM_W-1:0] v);
    int slot;
    if (shadow_fill[q] >= CNT_W'(QUEUE_DEPTH)) begin
      return;
    end
    slot = (int'(shadow_head[q]) + int'(shadow_fill[q])) % QUEUE_DEPTH;
    shadow_store[q][slot] = v;
    shadow_fill[q] = shadow_fill[q] + 1'b1;
  endfunction

  function automatic logic [ITEM_W-1:0] pop_shadow(input logic [QIDX_W-1:0] q);
    logic [ITEM_W-1:0] v;
    v = shadow_store[q][shadow_head[q]];
    shadow_head[q] = SLOT_W'((int'(shadow_head[q]) + 1) % QUEUE_DEPTH);
    shadow_fill[q] = shadow_fill[q] - 1'b1;
    return v;
  endfunction

  // advance the shadow rings by one command, queue the drain results of a dump
  function automatic void apply_command(input kind_e kind, input logic [QIDX_W-1:0] src,
                                        input logic [QIDX_W-1:0] dst,
                                        input logic [ITEM_W-1:0] value);
    logic [ITEM_W-1:0] moved;
    drain_rec_t        rec;
    case (kind)
      KIND_ADD: begin
        push_shadow((dst < QUEUE_LIM) ? dst : QUEUE_LAST, value);
      end
      KIND_MOVE: begin
        if (src < QUEUE_LIM && dst < QUEUE_LIM && shadow_fill[src] != '0) begin
          moved = pop_shadow(src);
          if (dst != src) begin
            push_shadow(dst, moved);
          end
        end
      end
      KIND_SERVE: begin
        if (src < QUEUE_LIM && shadow_fill[src] != '0) begin
          moved = pop_shadow(src);
        end
      end
      default: begin
        // drain 0, 1, 2; queue 2 always emits the final result
        for (int q = 0; q < QUEUE_COUNT; q++) begin
          rec.qidx = QIDX_W'(q);
          if (shadow_fill[q] == '0) begin
            rec.data  = '0;
            rec.empty = 1'b1;
            rec.last  = (q == QUEUE_COUNT - 1);
            pending_drain.push_back(rec);
          end else begin
            while (shadow_fill[q] != '0) begin
              rec.data  = pop_shadow(QIDX_W'(q));
              rec.empty = 1'b0;
              rec.last  = (q == QUEUE_COUNT - 1) && (shadow_fill[q] == '0);
              pending_drain.push_back(rec);
            end
          end
          shadow_head[q] = '0;
        end
      end
    endcase
  endfunction

  // present one item, hold it until taken, then idle at random
  task automatic send_command(input kind_e kind, input logic [QIDX_W-1:0] src,
                              input logic [QIDX_W-1:0] dst, input logic [ITEM_W-1:0] value);
    int gap;
    start          <= 1'b1;
    kind_i         <= kind;
    source_queue_i <= src;
    target_queue_i <= dst;
    item_value_i   <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_command(kind, src, dst, value);
    items_sent++;
    kind_count[kind]++;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending until every queued drain result has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_drain.size() != 0);
  endtask

  function automatic logic [QIDX_W-1:0] any_queue();
    return QIDX_W'($urandom_range(3));
  endfunction

  function automatic logic [QIDX_W-1:0] valid_queue();
    return QIDX_W'($urandom_range(QUEUE_COUNT - 1));
  endfunction

  function automatic logic [ITEM_W-1:0] any_value();
    return ITEM_W'($urandom_range(255));
  endfunction

  // result checker: compare each strobed result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    drain_rec_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      results_seen++;
      if (pending_drain.size() == 0) begin
        report_mismatch($sformatf("unexpected result q%0d item %02h empty %0b last %0b",
                                  queue_index_o, item_out_o, empty_marker_o, last_o));
      end else begin
        want = pending_drain.pop_front();
        if (queue_index_o !== want.qidx || item_out_o !== want.data ||
            empty_marker_o !== want.empty || last_o !== want.last) begin
          report_mismatch($sformatf(
            "expected q%0d item %02h empty %0b last %0b, got q%0d item %02h empty %0b last %0b",
            want.qidx, want.data, want.empty, want.last,
            queue_index_o, item_out_o, empty_marker_o, last_o));
        end
      end
    end
  end

  // dump with every queue empty: three markers
  task automatic test_empty_dump();
    send_command(KIND_DUMP, 2'd3, 2'd3, 8'hFF);
    wait_drained();
  endtask

  // adds to each queue, extreme bytes, target 3 folding into queue 2
  task automatic test_add_targets();
    send_command(KIND_ADD, 2'd0, 2'd0, 8'h00);
    send_command(KIND_ADD, 2'd3, 2'd1, 8'hFF);
    send_command(KIND_ADD, 2'd1, 2'd3, 8'h5A);
    send_command(KIND_ADD, 2'd2, 2'd2, 8'h81);
    send_command(KIND_DUMP, 2'd0, 2'd0, 8'h00);
    wait_drained();
  endtask

  // move between queues, to itself, to an out-of-range target, from none and from empty
  task automatic test_move_cases();
    send_command(KIND_ADD, 2'd0, 2'd0, 8'h11);
    send_command(KIND_ADD, 2'd0, 2'd0, 8'h22);
    send_command(KIND_ADD, 2'd0, 2'd1, 8'h33);
    send_command(KIND_MOVE, 2'd0, 2'd1, 8'hA5);
    send_command(KIND_MOVE, 2'd1, 2'd1, 8'h00);
    send_command(KIND_MOVE, 2'd0, 2'd3, 8'h00);
    send_command(KIND_MOVE, 2'd3, 2'd0, 8'h00);
    send_command(KIND_MOVE, 2'd2, 2'd0, 8'h00);
    send_command(KIND_DUMP, 2'd1, 2'd2, 8'h7E);
    wait_drained();
  endtask

  // serve a head, serve with no source, serve an empty queue
  task automatic test_serve_cases();
    send_command(KIND_ADD, 2'd0, 2'd2, 8'hC3);
    send_command(KIND_ADD, 2'd0, 2'd2, 8'h3C);
    send_command(KIND_SERVE, 2'd2, 2'd0, 8'h00);
    send_command(KIND_SERVE, 2'd3, 2'd2, 8'h00);
    send_command(KIND_SERVE, 2'd0, 2'd0, 8'h00);
    send_command(KIND_DUMP, 2'd3, 2'd1, 8'h00);
    wait_drained();
  endtask

  // mostly well-formed bursts, some full-queue overflow, some noise
  task automatic test_random_traffic(input int idle_pct, input int item_budget);
    int stop_at;
    int mode;
    logic [QIDX_W-1:0] q;
    logic [QIDX_W-1:0] src;
    sender_idle_pct = idle_pct;
    stop_at = items_sent + item_budget;
    while (items_sent < stop_at) begin
      mode = $urandom_range(9);
      if (mode < 6) begin
        repeat ($urandom_range(8, 2)) begin
          send_command(KIND_ADD, any_queue(), any_queue(), any_value());
        end
        repeat ($urandom_range(5, 1)) begin
          if ($urandom_range(1) == 0) begin
            send_command(KIND_MOVE, valid_queue(), valid_queue(), any_value());
          end else begin
            send_command(KIND_SERVE, valid_queue(), any_queue(), any_value());
          end
        end
        if ($urandom_range(2) == 0) begin
          send_command(KIND_DUMP, any_queue(), any_queue(), any_value());
        end
      end else if (mode == 6) begin
        // fill one queue up, then move into it so the popped item is lost
        q   = valid_queue();
        src = QIDX_W'((int'(q) + 1) % QUEUE_COUNT);
        repeat (QUEUE_DEPTH + $urandom_range(2)) begin
          send_command(KIND_ADD, any_queue(),
                       (q == QUEUE_LAST && $urandom_range(1) == 1) ? 2'd3 : q, any_value());
        end
        send_command(KIND_ADD, any_queue(), src, any_value());
        send_command(KIND_MOVE, src, q, any_value());
        send_command(KIND_DUMP, any_queue(), any_queue(), any_value());
      end else begin
        repeat ($urandom_range(4, 1)) begin
          send_command(kind_e'($urandom_range(3)), any_queue(), any_queue(), any_value());
        end
      end
    end
    wait_drained();
  endtask

  // main sequence
  initial begin
    start          <= 1'b0;
    kind_i         <= KIND_ADD;
    source_queue_i <= '0;
    target_queue_i <= '0;
    item_value_i   <= '0;
    rst_ni         <= 1'b0;
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      shadow_head[q] = '0;
      shadow_fill[q] = '0;
    end
    for (int k = 0; k < 4; k++) begin
      kind_count[k] = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_dump();
    test_add_targets();
    test_move_cases();
    test_serve_cases();
    test_random_traffic(0, 45);
    test_random_traffic(82, 45);
    test_random_traffic(23, 45);

    // let queued adds, moves and serves finish before the final check
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_drain.size() != 0) begin
      report_mismatch($sformatf("%0d drain results never arrived", pending_drain.size()));
    end

    $display("Sent %0d commands: %0d add, %0d move, %0d serve, %0d dump",
             items_sent, kind_count[KIND_ADD], kind_count[KIND_MOVE],
             kind_count[KIND_SERVE], kind_count[KIND_DUMP]);
    $display("Checked %0d drain results over three idle profiles, %0d mismatches",
             results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("three_queue_transfer_manager test passed");
    end else begin
      $display("three_queue_transfer_manager test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("Timeout: run did not complete");
    $display("three_queue_transfer_manager test failed");
    $finish;
  end

endmodule
